/* src/etf_pkg.sv */
// Shared constants, types and register codes for the escape-time fractal block.
`default_nettype none

package etf_pkg;

  // Number formats
  localparam int FRAC_BITS   = 28;               // fraction bits of every value
  localparam int COORD_WIDTH = 32;               // pixel and constant width
  localparam int ZW          = COORD_WIDTH + 4;  // width of z (Q8.28 by default)
  localparam int ITER_W      = 12;               // iteration count width
  localparam int PROD_W      = 2 * ZW;           // exact product width

  // Split of a z operand into a low unsigned half and a high signed half
  localparam int LO_W   = ZW / 2;
  localparam int HI_W   = ZW - LO_W;
  localparam int PART_W = LO_W + 1;              // signed width of either half
  localparam int MUL_W  = ZW + PART_W;           // partial product width

  // Escape radius: |z|^2 > 4.0, which is 2^(2*FRAC_BITS+2) in product units
  localparam int ESC_POS = 2 * FRAC_BITS + 2;
  localparam logic [PROD_W:0] ESC_LIMIT = (PROD_W + 1)'(1) << ESC_POS;

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = COORD_WIDTH;
  localparam logic [CFG_IDX_W-1:0] REG_FRACTAL_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_JULIA_CONST_RE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_JULIA_CONST_IM = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITERATIONS = 2'd3;

  localparam logic MODE_MANDELBROT = 1'b0;
  localparam logic MODE_JULIA      = 1'b1;

  localparam logic [ITER_W-1:0] MAX_ITER_RESET = 12'd256;

  // Configuration register bundle
  typedef struct packed {
    logic                          fractal_mode;
    logic signed [COORD_WIDTH-1:0] julia_const_re;
    logic signed [COORD_WIDTH-1:0] julia_const_im;
    logic [ITER_W-1:0]             max_iterations;
  } cfg_t;

  // One classified job: starting z and the c added each step
  typedef struct packed {
    logic signed [ZW-1:0]          z_re;
    logic signed [ZW-1:0]          z_im;
    logic signed [COORD_WIDTH-1:0] c_re;
    logic signed [COORD_WIDTH-1:0] c_im;
  } job_t;

  // One finished result
  typedef struct packed {
    logic [ITER_W-1:0] iter_count;
    logic              escaped;
  } result_t;

endpackage

`default_nettype wire

/* src/etf_front.sv */
// Front end: takes pixels and turns them into jobs by fractal mode.
`default_nettype none

module etf_front import etf_pkg::*; (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire cfg_t                          cfg,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [COORD_WIDTH-1:0] pixel_re,
  input  wire logic signed [COORD_WIDTH-1:0] pixel_im,
  output logic                               job_valid,
  input  wire logic                          job_ready,
  output job_t                               job
);

  logic job_next_valid;
  job_t job_next;

  // Stage frees up when empty or when its job moves into the queue
  assign in_ready = !job_valid || job_ready;

  // Mandelbrot starts at z = 0 with c = pixel, Julia starts at the pixel
  always_comb begin
    job_next = '0;
    unique case (cfg.fractal_mode)
      MODE_JULIA: begin
        job_next.z_re = ZW'(pixel_re);
        job_next.z_im = ZW'(pixel_im);
        job_next.c_re = cfg.julia_const_re;
        job_next.c_im = cfg.julia_const_im;
      end
      default: begin
        job_next.z_re = '0;
        job_next.z_im = '0;
        job_next.c_re = pixel_re;
        job_next.c_im = pixel_im;
      end
    endcase
  end

  assign job_next_valid = in_valid && in_ready;

  // Job register
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else begin
      if (job_next_valid) begin
        job_valid <= 1'b1;
        job       <= job_next;
      end else if (job_ready) begin
        job_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* src/etf_queue.sv */
// Small job queue that decouples the front end from the iteration engine.
`default_nettype none

module etf_queue import etf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire job_t push_job,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output job_t      pop_job
);

  job_t               entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    fill;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (fill != (QPTR_W + 1)'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_job    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + (QPTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - (QPTR_W + 1)'(1);
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= (QPTR_W + 1)'(QUEUE_DEPTH))
    else $error("queue fill level above depth");

endmodule

`default_nettype wire

/* src/etf_engine.sv */
// Back end: runs z = z*z + c on one job at a time and holds the result.
`default_nettype none

module etf_engine import etf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire logic job_valid,
  output logic      job_ready,
  input  wire job_t job,
  output logic      out_valid,
  input  wire logic out_ready,
  output result_t   result
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LO   = 2'd1;
  localparam logic [1:0] ST_HI   = 2'd2;
  localparam logic [1:0] ST_STEP = 2'd3;

  logic [1:0]                    state;
  logic signed [ZW-1:0]          z_re;
  logic signed [ZW-1:0]          z_im;
  logic signed [COORD_WIDTH-1:0] c_re;
  logic signed [COORD_WIDTH-1:0] c_im;
  logic [ITER_W-1:0]             iter;

  // Partial and full products
  logic signed [HI_W-1:0]   re_hi;
  logic signed [HI_W-1:0]   im_hi;
  logic signed [PART_W-1:0] part_re;
  logic signed [PART_W-1:0] part_im;
  logic signed [MUL_W-1:0]  m_sre;
  logic signed [MUL_W-1:0]  m_sim;
  logic signed [MUL_W-1:0]  m_x;
  logic signed [MUL_W-1:0]  lo_sre;
  logic signed [MUL_W-1:0]  lo_sim;
  logic signed [MUL_W-1:0]  lo_x;
  logic signed [PROD_W-1:0] sq_re;
  logic signed [PROD_W-1:0] sq_im;
  logic signed [PROD_W-1:0] xp;

  // Step logic
  logic [PROD_W:0]      mag_sum;
  logic [PROD_W:0]      diff;
  logic                 outside;
  logic                 at_limit;
  logic                 fin;
  logic                 res_free;
  logic                 res_load;
  logic signed [ZW-1:0] z_re_next;
  logic signed [ZW-1:0] z_im_next;

  assign job_ready = (state == ST_IDLE);
  assign out_valid = res_free ? 1'b0 : 1'b1;

  // Second operand half: low unsigned half first, high signed half next
  assign re_hi   = z_re[ZW-1:LO_W];
  assign im_hi   = z_im[ZW-1:LO_W];
  assign part_re = (state == ST_LO) ? $signed({1'b0, z_re[LO_W-1:0]}) : PART_W'(re_hi);
  assign part_im = (state == ST_LO) ? $signed({1'b0, z_im[LO_W-1:0]}) : PART_W'(im_hi);

  // Three multipliers: re*re, im*im, re*im
  assign m_sre = z_re * part_re;
  assign m_sim = z_im * part_im;
  assign m_x   = z_re * part_im;

  // Escape test against 4.0 and the next z
  assign mag_sum   = {1'b0, sq_re} + {1'b0, sq_im};
  assign outside   = (mag_sum > ESC_LIMIT);
  assign at_limit  = (iter >= cfg.max_iterations);
  assign fin       = outside || at_limit;
  assign diff      = {sq_re[PROD_W-1], sq_re} - {sq_im[PROD_W-1], sq_im};
  // z is inside radius 2 here, so the floored results fit ZW bits
  assign z_re_next = $signed(diff[FRAC_BITS +: ZW]) + ZW'(c_re);
  assign z_im_next = $signed(xp[FRAC_BITS-1 +: ZW]) + ZW'(c_im);

  // Result register flag: free when empty, loadable when free or being taken
  logic res_valid;
  assign res_free = !res_valid;
  assign res_load = (state == ST_STEP) && fin && (res_free || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (out_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (job_valid) begin
            z_re  <= job.z_re;
            z_im  <= job.z_im;
            c_re  <= job.c_re;
            c_im  <= job.c_im;
            iter  <= '0;
            state <= ST_LO;
          end
        end
        ST_LO: begin
          lo_sre <= m_sre;
          lo_sim <= m_sim;
          lo_x   <= m_x;
          state  <= ST_HI;
        end
        ST_HI: begin
          sq_re <= (PROD_W'(m_sre) <<< LO_W) + PROD_W'(lo_sre);
          sq_im <= (PROD_W'(m_sim) <<< LO_W) + PROD_W'(lo_sim);
          xp    <= (PROD_W'(m_x) <<< LO_W) + PROD_W'(lo_x);
          state <= ST_STEP;
        end
        ST_STEP: begin
          if (fin) begin
            // Hold here until the result register can take the transfer
            if (res_free || out_ready) begin
              result.iter_count <= iter;
              result.escaped    <= !at_limit;
              state             <= ST_IDLE;
            end
          end else begin
            z_re  <= z_re_next;
            z_im  <= z_im_next;
            iter  <= iter + ITER_W'(1);
            state <= ST_LO;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_lo_then_hi: assert property (@(posedge clk) disable iff (rst)
    state == ST_LO |=> state == ST_HI)
    else $error("multiply phases out of order");

  a_z_held: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LO || state == ST_HI) |=> $stable(iter) && $stable(z_re) && $stable(z_im))
    else $error("z or count changed during multiply phases");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STEP && fin && (res_free || out_ready)) |=> res_valid && state == ST_IDLE)
    else $error("finished job did not reach the result register");

endmodule

`default_nettype wire

/* src/escape_time_fractal_iteration.sv */
// Top level of the escape-time fractal iterator: config registers and the front/back split.
`default_nettype none

// Each pixel runs z = z*z + c (Mandelbrot: z0 = 0, c = pixel; Julia: z0 = pixel,
// c = configured constant) until |z|^2 > 4 or the count reaches max_iterations.
// In the iteration engine every update passes through ST_LO and ST_HI, the
// low and high halves of the 36x19 multiplies for re*re, im*im and re*im, and
// then ST_STEP, the escape test and the new z; the engine takes one item at a
// time. The default limit of max_iterations is 256.
// A front stage and a two-entry job queue keep taking pixels while the engine
// is busy and while a finished result waits in the output register.
module escape_time_fractal_iteration import etf_pkg::*; (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [COORD_WIDTH-1:0] pixel_re,
  input  wire logic signed [COORD_WIDTH-1:0] pixel_im,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [ITER_W-1:0]                  iter_count,
  output logic                               escaped
);

  cfg_t    cfg;
  logic    fj_valid;
  logic    fj_ready;
  job_t    fj_job;
  logic    qj_valid;
  logic    qj_ready;
  job_t    qj_job;
  result_t result;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fractal_mode   <= MODE_MANDELBROT;
      cfg.julia_const_re <= '0;
      cfg.julia_const_im <= '0;
      cfg.max_iterations <= MAX_ITER_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FRACTAL_MODE:   cfg.fractal_mode   <= cfg_data[0];
        REG_JULIA_CONST_RE: cfg.julia_const_re <= $signed(cfg_data[COORD_WIDTH-1:0]);
        REG_JULIA_CONST_IM: cfg.julia_const_im <= $signed(cfg_data[COORD_WIDTH-1:0]);
        REG_MAX_ITERATIONS: cfg.max_iterations <= cfg_data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  etf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pixel_re  (pixel_re),
    .pixel_im  (pixel_im),
    .job_valid (fj_valid),
    .job_ready (fj_ready),
    .job       (fj_job)
  );

  etf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fj_valid),
    .push_ready (fj_ready),
    .push_job   (fj_job),
    .pop_valid  (qj_valid),
    .pop_ready  (qj_ready),
    .pop_job    (qj_job)
  );

  etf_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_valid (qj_valid),
    .job_ready (qj_ready),
    .job       (qj_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  assign iter_count = result.iter_count;
  assign escaped    = result.escaped;

endmodule

`default_nettype wire
